@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the packed decimal decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/pdd_pkg.sv @@
// Package with types, constants and tables for the packed decimal decoder.
`timescale 1ns / 1ps
package pdd_pkg;

   localparam int MagW     = 28;
   localparam int QuoW     = 56;
   localparam int RemW     = 29;
   localparam int ExpW     = 11;
   localparam int DivSteps = 4;
   localparam int DivStages = QuoW / DivSteps;

   localparam logic [2:0] KIND_NUM  = 3'd0;
   localparam logic [2:0] KIND_ZERO = 3'd1;
   localparam logic [2:0] KIND_PINF = 3'd2;
   localparam logic [2:0] KIND_MINF = 3'd3;
   localparam logic [2:0] KIND_QNAN = 3'd4;

   localparam logic [2:0] SEL_DIV_1E7 = 3'd2;
   localparam logic [2:0] SEL_DIV_1E8 = 3'd3;
   localparam logic [2:0] SEL_DIV_128 = 3'd6;

   localparam logic [3:0] CODE_SPECIAL = 4'd0;
   localparam logic [3:0] CODE_LAST_UP = 4'd9;

   localparam logic [63:0] PINF_BITS = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] MINF_BITS = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

   localparam logic [MagW-1:0] NORM_128  = 28'h800_0000;
   localparam logic [4:0]      SHIFT_128 = 5'd20;

   localparam logic [ExpW-1:0] EXP_BIAS = 11'd1023;

   typedef struct packed {
      logic            valid;
      logic [2:0]      kind;
      logic            sign;
      logic            is_div;
      logic [MagW-1:0] mag;
      logic [4:0]      lead;
      logic [MagW-1:0] cnst;
      logic [4:0]      cshift;
      logic [ExpW-1:0] exp_base;
   } front_type;

   typedef struct packed {
      logic            valid;
      logic [2:0]      kind;
      logic            sign;
      logic            is_div;
      logic [ExpW-1:0] exp_base;
      logic [MagW-1:0] dvs;
      logic [RemW-1:0] rem;
      logic [QuoW-1:0] quo;
      logic [QuoW-1:0] prod;
   } div_type;

   typedef struct packed {
      logic            valid;
      logic [2:0]      kind;
      logic            sign;
      logic [ExpW-1:0] expo;
      logic [QuoW-1:0] sig;
      logic            sticky;
   } norm_type;

   // 10^k shifted so that its leading one sits in bit 27.
   function automatic logic [MagW-1:0] pow10_norm(input logic [3:0] k);
      logic [MagW-1:0] v;
      case (k)
         4'd0:    v = 28'h800_0000;
         4'd1:    v = 28'hA00_0000;
         4'd2:    v = 28'hC80_0000;
         4'd3:    v = 28'hFA0_0000;
         4'd4:    v = 28'h9C4_0000;
         4'd5:    v = 28'hC35_0000;
         4'd6:    v = 28'hF42_4000;
         4'd7:    v = 28'h989_6800;
         4'd8:    v = 28'hBEB_C200;
         default: v = 28'h800_0000;
      endcase
      return v;
   endfunction

   // Left shift applied to 10^k by pow10_norm.
   function automatic logic [4:0] pow10_shift(input logic [3:0] k);
      logic [4:0] s;
      case (k)
         4'd0:    s = 5'd27;
         4'd1:    s = 5'd24;
         4'd2:    s = 5'd21;
         4'd3:    s = 5'd18;
         4'd4:    s = 5'd14;
         4'd5:    s = 5'd11;
         4'd6:    s = 5'd8;
         4'd7:    s = 5'd4;
         4'd8:    s = 5'd1;
         default: s = 5'd27;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/packed_decimal_to_double.sv @@
// Top level of the packed decimal to binary64 decoder.
`timescale 1ns / 1ps
// Usage
// The req_ channel takes one 32-bit packed decimal word per handshake: power
// code in bits 3:0, signed mantissa in bits 31:4 (31:7 in the extended
// formats, selected in bits 6:4). The rsp_ channel returns one 64-bit word
// per input word, the binary64 bit pattern of the decoded value, rounded to
// nearest even. Throughput is one word per cycle while the receiver does
// not stall. From acceptance to rsp_tvalid a word passes three front stages
// (decode, leading-zero count, normalise), fourteen divider stages that
// each retire four quotient bits of a restoring division (the multiply for
// positive powers happens beside the first), a normalising stage and the
// rounding stage feeding the output register. The divider sets the latency.
// When the receiver stalls with a word on the output, the whole pipeline
// holds and req_tready drops; nothing is lost or repeated. Synchronous reset
// clears every valid bit; payload registers are left alone.
`include "assert_macros.svh"

module packed_decimal_to_double (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] packed_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] result_bits
);

   // Global advance: every stage moves when the output is free or being taken.
   logic adv;

   pdd_pkg::front_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   pdd_pkg::div_type   ds_ff [pdd_pkg::DivStages];
   pdd_pkg::div_type   ds_in [pdd_pkg::DivStages];
   pdd_pkg::norm_type  nm_ff, nm_in;
   logic               out_valid_ff, out_valid_in;
   logic [63:0]        out_data_ff, out_data_in;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Stage 1: decode the power code and pick the scale constant.
   always_comb begin
      logic [3:0]               code;
      logic [2:0]               sel;
      logic signed [pdd_pkg::MagW-1:0] num;
      logic                     ext;
      logic [3:0]               pidx;
      code = req_tdata[3:0];
      sel  = req_tdata[6:4];
      num  = req_tdata[31:4];
      ext  = 1'b0;
      pidx = 4'd0;
      s1_in = '0;
      s1_in.valid  = req_tvalid;
      s1_in.kind   = pdd_pkg::KIND_NUM;
      s1_in.is_div = 1'b0;
      s1_in.cnst   = pdd_pkg::pow10_norm(4'd0);
      s1_in.cshift = pdd_pkg::pow10_shift(4'd0);
      if (code == pdd_pkg::CODE_SPECIAL) begin
         unique case (sel)
            pdd_pkg::SEL_DIV_1E7: begin
               ext  = 1'b1;
               pidx = 4'd7;
            end
            pdd_pkg::SEL_DIV_1E8: begin
               ext  = 1'b1;
               pidx = 4'd8;
            end
            pdd_pkg::SEL_DIV_128: begin
               ext  = 1'b1;
            end
            default: begin
               ext = 1'b0;
            end
         endcase
         if (ext) begin
            num          = {{3{req_tdata[31]}}, req_tdata[31:7]};
            s1_in.is_div = 1'b1;
            if (sel == pdd_pkg::SEL_DIV_128) begin
               s1_in.cnst   = pdd_pkg::NORM_128;
               s1_in.cshift = pdd_pkg::SHIFT_128;
            end else begin
               s1_in.cnst   = pdd_pkg::pow10_norm(pidx);
               s1_in.cshift = pdd_pkg::pow10_shift(pidx);
            end
         end
      end else if (code <= pdd_pkg::CODE_LAST_UP) begin
         pidx         = pdd_pkg::CODE_LAST_UP - code;
         s1_in.cnst   = pdd_pkg::pow10_norm(pidx);
         s1_in.cshift = pdd_pkg::pow10_shift(pidx);
      end else begin
         pidx         = code - pdd_pkg::CODE_LAST_UP;
         s1_in.is_div = 1'b1;
         s1_in.cnst   = pdd_pkg::pow10_norm(pidx);
         s1_in.cshift = pdd_pkg::pow10_shift(pidx);
      end
      s1_in.sign = num[pdd_pkg::MagW-1];
      s1_in.mag  = num[pdd_pkg::MagW-1] ? 28'(-num) : 28'(num);
      if (code == pdd_pkg::CODE_SPECIAL && !ext) begin
         if (num == '0) begin
            s1_in.kind = pdd_pkg::KIND_QNAN;
         end else if (num[pdd_pkg::MagW-1]) begin
            s1_in.kind = pdd_pkg::KIND_MINF;
         end else begin
            s1_in.kind = pdd_pkg::KIND_PINF;
         end
      end else if (num == '0) begin
         s1_in.kind = pdd_pkg::KIND_ZERO;
      end
   end

   // Stage 2: count leading zeros of the magnitude.
   always_comb begin
      s2_in      = s1_ff;
      s2_in.lead = '0;
      for (int i = 0; i < pdd_pkg::MagW; i++) begin
         if (s1_ff.mag[i]) begin
            s2_in.lead = 5'(pdd_pkg::MagW - 1 - i);
         end
      end
   end

   // Stage 3: normalise the magnitude and form the biased exponent base.
   always_comb begin
      s3_in     = s2_ff;
      s3_in.mag = s2_ff.mag << s2_ff.lead;
      if (s2_ff.is_div) begin
         s3_in.exp_base = pdd_pkg::EXP_BIAS + 11'(s2_ff.cshift) - 11'(s2_ff.lead)
                          - 11'(pdd_pkg::QuoW - 1);
      end else begin
         s3_in.exp_base = pdd_pkg::EXP_BIAS - 11'(s2_ff.lead) - 11'(s2_ff.cshift);
      end
   end

   // Divider stages: restoring division, four quotient bits per stage.
   // The product for positive powers is formed beside the first stage.
   always_comb begin
      pdd_pkg::div_type cur;
      for (int s = 0; s < pdd_pkg::DivStages; s++) begin
         if (s == 0) begin
            cur.valid    = s3_ff.valid;
            cur.kind     = s3_ff.kind;
            cur.sign     = s3_ff.sign;
            cur.is_div   = s3_ff.is_div;
            cur.exp_base = s3_ff.exp_base;
            cur.dvs      = s3_ff.cnst;
            cur.rem      = {1'b0, s3_ff.mag};
            cur.quo      = '0;
            cur.prod     = 56'(s3_ff.mag) * 56'(s3_ff.cnst);
         end else begin
            cur = ds_ff[s-1];
         end
         for (int k = 0; k < pdd_pkg::DivSteps; k++) begin
            if (cur.rem >= {1'b0, cur.dvs}) begin
               cur.rem = cur.rem - {1'b0, cur.dvs};
               cur.quo = {cur.quo[pdd_pkg::QuoW-2:0], 1'b1};
            end else begin
               cur.quo = {cur.quo[pdd_pkg::QuoW-2:0], 1'b0};
            end
            cur.rem = {cur.rem[pdd_pkg::RemW-2:0], 1'b0};
         end
         ds_in[s] = cur;
      end
   end

   // Normalising stage: leading one of quotient or product into bit 55.
   always_comb begin
      logic [pdd_pkg::QuoW-1:0] top;
      pdd_pkg::div_type         last;
      last  = ds_ff[pdd_pkg::DivStages-1];
      top   = last.is_div ? last.quo : last.prod;
      nm_in.valid  = last.valid;
      nm_in.kind   = last.kind;
      nm_in.sign   = last.sign;
      nm_in.sticky = last.is_div && (last.rem != '0);
      if (top[pdd_pkg::QuoW-1]) begin
         nm_in.sig  = top;
         nm_in.expo = last.exp_base + 11'(pdd_pkg::QuoW - 1);
      end else begin
         nm_in.sig  = {top[pdd_pkg::QuoW-2:0], 1'b0};
         nm_in.expo = last.exp_base + 11'(pdd_pkg::QuoW - 2);
      end
   end

   // Rounding stage: round to nearest even and assemble the binary64 word.
   always_comb begin
      logic [52:0] mant;
      logic        grd;
      logic        stk;
      logic        up;
      logic [53:0] sum;
      logic [10:0] expo;
      mant = nm_ff.sig[55:3];
      grd  = nm_ff.sig[2];
      stk  = nm_ff.sig[1] | nm_ff.sig[0] | nm_ff.sticky;
      up   = grd && (stk || mant[0]);
      sum  = {1'b0, mant} + 54'(up);
      expo = nm_ff.expo + 11'(sum[53]);
      out_valid_in = nm_ff.valid;
      case (nm_ff.kind)
         pdd_pkg::KIND_ZERO: out_data_in = '0;
         pdd_pkg::KIND_PINF: out_data_in = pdd_pkg::PINF_BITS;
         pdd_pkg::KIND_MINF: out_data_in = pdd_pkg::MINF_BITS;
         pdd_pkg::KIND_QNAN: out_data_in = pdd_pkg::QNAN_BITS;
         default:            out_data_in = {nm_ff.sign, expo, sum[51:0]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         nm_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s < pdd_pkg::DivStages; s++) begin
            ds_ff[s].valid <= 1'b0;
         end
      end else if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         nm_ff        <= nm_in;
         out_valid_ff <= out_valid_in;
         for (int s = 0; s < pdd_pkg::DivStages; s++) begin
            ds_ff[s] <= ds_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   // A numeric word reaching rounding has its leading one in place.
   `ASSERT_IMP(a_norm_lead, clock, reset, nm_ff.valid && nm_ff.kind == pdd_pkg::KIND_NUM, nm_ff.sig[pdd_pkg::QuoW-1])
   // The final divider remainder stays below twice the divisor.
   `ASSERT_IMP(a_rem_bound, clock, reset, ds_ff[pdd_pkg::DivStages-1].valid, ds_ff[pdd_pkg::DivStages-1].rem < {ds_ff[pdd_pkg::DivStages-1].dvs, 1'b0})
   // While the output is held, the stage in front of it keeps its word.
   `ASSERT_NXT(a_stall_hold, clock, reset, !adv, $stable(nm_ff) && $stable(out_data_ff))

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the packed decimal to binary64 decoder.
`timescale 1ns / 1ps

module testbench;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] packed_word
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [63:0] result_bits

   // Latency of the block, used to drain the pipeline at the end.
   localparam int Latency    = 19;
   localparam int CycleLimit = 200000;
   localparam int RandomWords = 400;

   packed_decimal_to_double dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // One row of the directed table: a word and, where it is obvious, its result.
   typedef struct {
      logic [31:0] word;
      logic        fixed;
      logic [63:0] bits;
   } directed_row_type;

   logic [63:0] pending_doubles[$];
   int          mismatches = 0;
   int          words_checked = 0;
   int          cycle_count = 0;
   bit          calm_sender;
   bit          calm_receiver;

   // Sign-extends the low n bits of v.
   function automatic longint signed_field(input logic [31:0] v, input int n);
      longint x;
      x = longint'(v) & ((longint'(1) << n) - 1);
      if (x[n-1])
         x = x - (longint'(1) << n);
      return x;
   endfunction

   // Works out the binary64 pattern of one packed decimal word.
   function automatic logic [63:0] decode_double(input logic [31:0] w);
      logic [3:0] code;
      logic [2:0] sel;
      longint     m28;
      longint     m25;
      real        divisor;
      real        up[10];
      real        down[6];
      code = w[3:0];
      sel  = w[6:4];
      m28  = signed_field(w >> 4, 28);
      m25  = signed_field(w >> 7, 25);
      up   = '{0.0, 1.0e8, 1.0e7, 1.0e6, 1.0e5, 1.0e4, 1.0e3, 100.0, 10.0, 1.0};
      down = '{10.0, 100.0, 1.0e3, 1.0e4, 1.0e5, 1.0e6};
      if (code == pdd_pkg::CODE_SPECIAL) begin
         divisor = 0.0;
         if (sel == pdd_pkg::SEL_DIV_1E7) divisor = 1.0e7;
         else if (sel == pdd_pkg::SEL_DIV_1E8) divisor = 1.0e8;
         else if (sel == pdd_pkg::SEL_DIV_128) divisor = 128.0;
         if (divisor != 0.0) return $realtobits(real'(m25) / divisor);
         if (m28 == 0) return pdd_pkg::QNAN_BITS;
         if (m28 < 0) return pdd_pkg::MINF_BITS;
         return pdd_pkg::PINF_BITS;
      end
      if (code <= pdd_pkg::CODE_LAST_UP) return $realtobits(real'(m28) * up[code]);
      return $realtobits(real'(m28) / down[code - 10]);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s at cycle %0d: got %h, expected %h", what, cycle_count,
               got, want);
      mismatches++;
   endtask

   // Result checking at the rising edge; the receiver's stalls are drawn below.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_doubles.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, '0);
            end else begin
               if (rsp_tdata !== pending_doubles[0])
                  report_mismatch("result_bits", rsp_tdata, pending_doubles[0]);
               void'(pending_doubles.pop_front());
               words_checked++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (calm_receiver)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Offers one word, with random idle cycles before it, and waits for acceptance.
   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [31:0] w, input logic [63:0] want);
      while (!calm_sender && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      pending_doubles.push_back(want);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Builds a random word, weighted towards the special code and its formats.
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(7))
         0: w[3:0] = pdd_pkg::CODE_SPECIAL;
         1: begin
            w[3:0] = pdd_pkg::CODE_SPECIAL;
            w[6:4] = ($urandom_range(1)) ? pdd_pkg::SEL_DIV_128 : pdd_pkg::SEL_DIV_1E7;
         end
         2: w = {$urandom_range(1) ? 4'hF : 4'h0, w[27:0] & 28'h0FF_FFFF};
         default: ;
      endcase
      return w;
   endfunction

   directed_row_type table_rows[$];
   logic [31:0] w;

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      calm_sender = 1'b0;
      calm_receiver = 1'b0;
      // Zero times infinity, the two infinities, zeros, extremes and each format.
      table_rows = '{
         '{32'h0000_0000, 1'b1, pdd_pkg::QNAN_BITS},
         '{32'h0000_0010, 1'b1, pdd_pkg::PINF_BITS},
         '{32'hFFFF_FFF0, 1'b1, pdd_pkg::MINF_BITS},
         '{32'h7FFF_FFF0, 1'b1, pdd_pkg::PINF_BITS},
         '{32'h8000_0040, 1'b1, pdd_pkg::MINF_BITS},
         '{32'h8000_0070, 1'b1, pdd_pkg::MINF_BITS},
         '{32'h0000_0050, 1'b1, pdd_pkg::PINF_BITS},
         '{32'h0000_0009, 1'b1, 64'h0000_0000_0000_0000},
         '{32'h0000_0001, 1'b1, 64'h0000_0000_0000_0000},
         '{32'h0000_000F, 1'b1, 64'h0000_0000_0000_0000},
         '{32'h0000_0019, 1'b1, 64'h3FF0_0000_0000_0000},
         '{32'hFFFF_FFF9, 1'b1, 64'hBFF0_0000_0000_0000},
         '{32'h0000_0020, 1'b1, 64'h0000_0000_0000_0000},
         '{32'hFFFF_FFA0, 1'b0, '0},
         '{32'h7FFF_FFB0, 1'b0, '0},
         '{32'h8000_0030, 1'b0, '0},
         '{32'hFFFF_FFE0, 1'b0, '0},
         '{32'h7FFF_FFE0, 1'b0, '0},
         '{32'h7FFF_FFF1, 1'b0, '0},
         '{32'h8000_0001, 1'b0, '0},
         '{32'h7FFF_FFF5, 1'b0, '0},
         '{32'h7FFF_FFFA, 1'b0, '0},
         '{32'h8000_000C, 1'b0, '0},
         '{32'h1234_567E, 1'b0, '0},
         '{32'hFFFF_FFFF, 1'b0, '0}
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i])
         send_word(table_rows[i].word,
                   table_rows[i].fixed ? table_rows[i].bits
                                       : decode_double(table_rows[i].word));

      // Random words: the middle stretch runs with both sides never idling.
      for (int n = 0; n < RandomWords; n++) begin
         calm_sender   = (n >= 150 && n < 250);
         calm_receiver = calm_sender;
         w = random_word();
         send_word(w, decode_double(w));
      end
      req_tvalid    <= 1'b0;
      calm_sender   = 1'b0;
      calm_receiver = 1'b0;

      while (pending_doubles.size() != 0)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);

      $display("Checked %0d result words from %0d directed and %0d random inputs,",
               words_checked, table_rows.size(), RandomWords);
      $display("covering every power code, extended formats and special values.");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
